// ===== sv/ssa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared constants, codes and types for the swap slot allocator.
// ----------------------------------------------------------------------------
package ssa_pkg;
    localparam int SLOTS   = 1024;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = 16;
    localparam int AMT_W   = 15;
    localparam int CSZ_W   = 9;
    localparam int CLUSTER_LIMIT = 256;

    localparam logic [CNT_W-1:0] COUNT_MAX = 16'h7FFF;
    localparam logic [CNT_W-1:0] COUNT_BAD = 16'h8000;

    localparam logic [2:0] ACT_ALLOC = 3'd0;
    localparam logic [2:0] ACT_DUP   = 3'd1;
    localparam logic [2:0] ACT_FREE  = 3'd2;
    localparam logic [2:0] ACT_COUNT = 3'd3;
    localparam logic [2:0] ACT_BAD   = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO      = 3'd1;
    localparam logic [2:0] ST_UNUSED    = 3'd2;
    localparam logic [2:0] ST_AMOUNT    = 3'd3;
    localparam logic [2:0] ST_NOSPACE   = 3'd4;
    localparam logic [2:0] ST_UNDERFLOW = 3'd5;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CNT_W-1:0]  t_count;
endpackage

// ===== sv/ssa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_ram
// Generic single-port RAM, registered read, write-first not required.
// ----------------------------------------------------------------------------
module ssa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== sv/swap_slot_allocator_refcount.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swap_slot_allocator_refcount
// Slot map of 16-bit reference counts with cluster allocation.
// ----------------------------------------------------------------------------
// Channel | signals                                  | handshake
// cmd     | i_action i_slot i_amount                  | i_start & !o_busy
// result  | o_result_slot o_ref_count o_status        | o_done strobe, 1 cycle
// cfg     | i_cfg_data (cluster_size)                 | i_cfg_valid & o_cfg_ready
//
// Steps: single-slot actions keep o_busy high through read, modify/write and
// result; the strobe comes in the cycle after, when a new item may be taken.
// Rejected items (slot zero, unknown action, large amount, no free slots)
// go straight to result. Allocate scans the count RAM through its single port:
// cluster continuation and first fit issue and then check each probe, the run
// search issues once per restart and then checks one probe after another, and
// a write and an answer follow. After reset a clearing pass writes every entry
// (o_busy high); configuration writes are taken any time.
// The result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module swap_slot_allocator_refcount (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [2:0]                   i_action,
    input  logic [ssa_pkg::SLOT_W-1:0]   i_slot,
    input  logic [ssa_pkg::AMT_W-1:0]    i_amount,
    output logic                         o_done,
    output logic [ssa_pkg::SLOT_W-1:0]   o_result_slot,
    output logic [ssa_pkg::CNT_W-1:0]    o_ref_count,
    output logic [2:0]                   o_status,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [ssa_pkg::CSZ_W-1:0]    i_cfg_data
);
    localparam int SW = ssa_pkg::SLOT_W;
    localparam int PW = SW + 1;   // position, can reach SLOTS
    localparam int CW = ssa_pkg::CSZ_W;

    // state codes
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;  // single-slot read wait
    localparam logic [3:0] S_OP    = 4'd3;  // single-slot modify
    localparam logic [3:0] S_C1    = 4'd4;  // cluster continue: issue
    localparam logic [3:0] S_C2    = 4'd5;  // cluster continue: check
    localparam logic [3:0] S_R1    = 4'd6;  // run search issue
    localparam logic [3:0] S_R2    = 4'd7;  // run search check
    localparam logic [3:0] S_F1    = 4'd8;  // first fit issue
    localparam logic [3:0] S_F2    = 4'd9;  // first fit check
    localparam logic [3:0] S_TAKE  = 4'd10; // write allocated slot
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0]  r_state, n_state;
    logic [PW-1:0] r_clr;
    logic [CW-1:0] r_csize;
    logic [PW-1:0] r_low;     // can step past the last slot
    logic [SW-1:0] r_high;
    logic [PW-1:0] r_cpos;
    logic [CW-1:0] r_cleft;
    logic [PW-1:0] r_free;
    logic [2:0]  r_act;
    logic [SW-1:0] r_slot;
    logic [ssa_pkg::AMT_W-1:0] r_amt;
    logic [PW-1:0] r_off;     // run start / first-fit cursor
    logic [PW-1:0] r_scan;    // current probe address
    logic [CW-1:0] r_run;
    logic [SW-1:0] r_res_slot;
    logic [ssa_pkg::CNT_W-1:0] r_res_cnt;
    logic [2:0]  r_res_st;
    logic        r_done;

    logic        we;
    logic [SW-1:0] addr;
    ssa_pkg::t_count wdata, rdata;

    ssa_ram #(.WIDTH(ssa_pkg::CNT_W), .DEPTH(ssa_pkg::SLOTS)) u_map (
        .i_clk(i_clk), .i_we(we), .i_addr(addr), .i_wdata(wdata), .o_rdata(rdata)
    );

    // effective run length, clamped 1..256
    logic [CW-1:0] run_len;
    always_comb begin
        if (r_csize == '0) run_len = CW'(1);
        else if (r_csize > CW'(ssa_pkg::CLUSTER_LIMIT)) run_len = CW'(ssa_pkg::CLUSTER_LIMIT);
        else run_len = r_csize;
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_done        = r_done;
    assign o_result_slot = r_res_slot;
    assign o_ref_count   = r_res_cnt;
    assign o_status      = r_res_st;

    // run end check: off + run - 1 <= high
    logic [PW:0] run_end;
    assign run_end = {1'b0, r_off} + (PW+1)'(r_run) - (PW+1)'(1);

    always_comb begin
        n_state = r_state;
        we      = 1'b0;
        addr    = r_scan[SW-1:0];
        wdata   = '0;
        unique case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                addr  = r_clr[SW-1:0];
                wdata = (r_clr == '0) ? ssa_pkg::COUNT_BAD : '0;
                if (r_clr == PW'(ssa_pkg::SLOTS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                addr = i_slot;
                if (i_start) begin
                    if (i_action == ssa_pkg::ACT_ALLOC) begin
                        if ({1'b0, i_amount} >= ssa_pkg::COUNT_MAX || r_free == '0)
                            n_state = S_DONE;
                        else if (r_cleft != '0) n_state = S_C1;
                        else n_state = S_R1;
                    end else if (i_action <= ssa_pkg::ACT_BAD && i_slot != '0)
                        n_state = S_RD;
                    else n_state = S_DONE;
                end
            end
            S_RD: begin
                addr    = r_slot;
                n_state = S_OP;
            end
            S_OP: begin
                addr = r_slot;
                n_state = S_DONE;
                if (r_act == ssa_pkg::ACT_BAD) begin
                    we = 1'b1; wdata = ssa_pkg::COUNT_BAD;
                end else if (rdata != '0) begin
                    if (r_act == ssa_pkg::ACT_DUP) begin
                        we = 1'b1;
                        wdata = (rdata < ssa_pkg::COUNT_MAX) ? rdata + 16'd1 : ssa_pkg::COUNT_MAX;
                    end else if (r_act == ssa_pkg::ACT_FREE && rdata < ssa_pkg::COUNT_MAX
                                 && rdata >= {1'b0, r_amt}) begin
                        we = 1'b1; wdata = rdata - {1'b0, r_amt};
                    end
                end
            end
            S_C1: begin
                if (r_cpos <= {1'b0, r_high} && r_cpos < PW'(ssa_pkg::SLOTS))
                    n_state = S_C2;
                else n_state = S_R1;
            end
            S_C2: begin
                if (rdata == '0) n_state = S_TAKE;
                else n_state = S_C1;
            end
            S_R1: begin
                if (run_end <= (PW+1)'(r_high)) n_state = S_R2;
                else n_state = S_F1;
            end
            S_R2: begin
                if (rdata != '0) n_state = S_R1;
                else if (r_scan == r_off + PW'(r_run) - PW'(1)) n_state = S_TAKE;
                else n_state = S_R2;
            end
            S_F1: begin
                if (r_off <= {1'b0, r_high} && r_off < PW'(ssa_pkg::SLOTS)) n_state = S_F2;
                else n_state = S_DONE;
            end
            S_F2: begin
                if (rdata == '0) n_state = S_TAKE;
                else n_state = S_F1;
            end
            S_TAKE: begin
                we = 1'b1; addr = r_off[SW-1:0]; wdata = {1'b0, r_amt};
                n_state = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        // probe address for scanning states
        if (r_state == S_C1) addr = r_cpos[SW-1:0];
        if (r_state == S_R1) addr = r_scan[SW-1:0];
        if (r_state == S_R2) addr = r_scan[SW-1:0] + SW'(1);
        if (r_state == S_F1) addr = r_off[SW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_csize <= CW'(ssa_pkg::CLUSTER_LIMIT);
            r_low   <= PW'(1);
            r_high  <= SW'(ssa_pkg::SLOTS - 1);
            r_cpos  <= '0;
            r_cleft <= '0;
            r_free  <= PW'(ssa_pkg::SLOTS - 1);
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_DONE);
            if (i_cfg_valid) r_csize <= i_cfg_data;
            unique case (r_state)
                S_CLEAR: r_clr <= r_clr + PW'(1);
                S_IDLE: if (i_start) begin
                    r_act <= i_action; r_slot <= i_slot; r_amt <= i_amount;
                    r_res_slot <= '0; r_res_cnt <= '0;
                    if (i_action == ssa_pkg::ACT_ALLOC) begin
                        if ({1'b0, i_amount} >= ssa_pkg::COUNT_MAX) r_res_st <= ssa_pkg::ST_AMOUNT;
                        else if (r_free == '0) r_res_st <= ssa_pkg::ST_NOSPACE;
                        else begin
                            r_res_st <= ssa_pkg::ST_OK;
                            if (r_cleft == '0) begin
                                r_cleft <= run_len; r_run <= run_len;
                                r_off <= r_low; r_scan <= r_low;
                            end
                        end
                    end else if (i_action <= ssa_pkg::ACT_BAD && i_slot == '0)
                        r_res_st <= ssa_pkg::ST_ZERO;
                    else
                        r_res_st <= ssa_pkg::ST_OK;
                end
                S_OP: begin
                    if (r_act == ssa_pkg::ACT_BAD) begin
                        if (rdata == '0 && r_free != '0) r_free <= r_free - PW'(1);
                    end else if (rdata == '0) r_res_st <= ssa_pkg::ST_UNUSED;
                    else if (r_act == ssa_pkg::ACT_COUNT) r_res_cnt <= rdata;
                    else if (r_act == ssa_pkg::ACT_FREE && rdata < ssa_pkg::COUNT_MAX) begin
                        if (rdata < {1'b0, r_amt}) r_res_st <= ssa_pkg::ST_UNDERFLOW;
                        else if (rdata == {1'b0, r_amt}) begin
                            if ({1'b0, r_slot} < r_low) r_low <= {1'b0, r_slot};
                            if (r_slot > r_high) r_high <= r_slot;
                            r_free <= r_free + PW'(1);
                        end
                    end
                end
                S_C1: begin
                    if (r_cpos <= {1'b0, r_high} && r_cpos < PW'(ssa_pkg::SLOTS)) begin
                        r_off  <= r_cpos;
                        r_cpos <= r_cpos + PW'(1);
                    end else begin
                        r_cleft <= run_len; r_run <= run_len;
                        r_off <= r_low; r_scan <= r_low;
                    end
                end
                S_C2: if (rdata == '0) r_cleft <= r_cleft - CW'(1);
                S_R1: if (run_end > (PW+1)'(r_high)) r_off <= r_low;
                S_R2: begin
                    if (rdata != '0) begin
                        r_off <= r_scan + PW'(1); r_scan <= r_scan + PW'(1);
                    end else if (r_scan != r_off + PW'(r_run) - PW'(1))
                        r_scan <= r_scan + PW'(1);
                end
                S_F1: if (!(r_off <= {1'b0, r_high} && r_off < PW'(ssa_pkg::SLOTS)))
                    r_res_st <= ssa_pkg::ST_NOSPACE;
                S_F2: if (rdata != '0) r_off <= r_off + PW'(1);
                S_TAKE: begin
                    r_res_slot <= r_off[SW-1:0];
                    if (r_off == r_low) r_low <= r_low + PW'(1);
                    if (r_off[SW-1:0] == r_high && r_high != '0) r_high <= r_high - SW'(1);
                    if (r_free != '0) r_free <= r_free - PW'(1);
                    r_cpos <= r_off + PW'(1);
                end
                default: ;
            endcase
        end
    end

    // assertions
    a_done_after_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> o_done)
        else $error("result strobe missing");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_state == S_IDLE))
        else $error("strobe outside idle");
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= PW'(ssa_pkg::SLOTS - 1))
        else $error("free count overflow");
    a_fail_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ssa_pkg::ST_OK) |-> (o_result_slot == '0))
        else $error("slot on failure");
endmodule

// ===== tb/ssa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_checker
// Watches the command, config and result channels of the slot allocator,
// keeps its own slot map, predicts each result and compares it.
// ----------------------------------------------------------------------------
module ssa_checker
    import ssa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [2:0]         i_action,
    input  logic [SLOT_W-1:0]  i_slot,
    input  logic [AMT_W-1:0]   i_amount,
    input  logic               i_done,
    input  logic [SLOT_W-1:0]  i_result_slot,
    input  logic [CNT_W-1:0]   i_ref_count,
    input  logic [2:0]         i_status,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [CSZ_W-1:0]   i_cfg_data,
    output int                 o_errors,
    output int                 o_pending
);
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  count;
        logic [2:0]        status;
    } t_answer;

    t_count            map_count [SLOTS];
    int                low_mark, high_mark, clu_pos, clu_left, free_cnt;
    logic [CSZ_W-1:0]  clu_size;
    t_answer           due_answers[$];

    function automatic int run_len();
        if (clu_size == '0) return 1;
        if (clu_size > CLUSTER_LIMIT) return CLUSTER_LIMIT;
        return int'(clu_size);
    endfunction

    function automatic int take_slot(int off, int amt);
        if (off == low_mark) low_mark++;
        if (off == high_mark && high_mark > 0) high_mark--;
        map_count[off] = t_count'(amt);
        if (free_cnt > 0) free_cnt--;
        clu_pos = off + 1;
        return off;
    endfunction

    function automatic int find_slot(int amt);
        int  run;
        int  off;
        bit  clash;
        run = run_len();
        if (clu_left != 0) begin
            while (clu_pos <= high_mark && clu_pos < SLOTS) begin
                off = clu_pos;
                clu_pos++;
                if (map_count[off] == '0) begin
                    clu_left--;
                    return take_slot(off, amt);
                end
            end
        end
        clu_left = run;
        off = low_mark;
        while (off + run - 1 <= high_mark) begin
            clash = 0;
            for (int i = off; i < off + run; i++) begin
                if (map_count[i] != '0) begin
                    off = i + 1;
                    clash = 1;
                    break;
                end
            end
            if (!clash) return take_slot(off, amt);
        end
        for (off = low_mark; off <= high_mark && off < SLOTS; off++)
            if (map_count[off] == '0) return take_slot(off, amt);
        return 0;
    endfunction

    function automatic t_answer apply_command(logic [2:0] act, t_slot s,
                                              logic [AMT_W-1:0] amt);
        t_answer a;
        t_count  cur;
        a = '0;
        a.status = ST_OK;
        if (act == ACT_ALLOC) begin
            if (amt >= COUNT_MAX[AMT_W-1:0]) a.status = ST_AMOUNT;
            else if (free_cnt == 0) a.status = ST_NOSPACE;
            else begin
                a.slot = t_slot'(find_slot(int'(amt)));
                if (a.slot == '0) a.status = ST_NOSPACE;
            end
        end else if (act <= ACT_BAD) begin
            if (s == '0) a.status = ST_ZERO;
            else begin
                cur = map_count[s];
                if (act == ACT_BAD) begin
                    if (cur == '0 && free_cnt > 0) free_cnt--;
                    map_count[s] = COUNT_BAD;
                end else if (cur == '0) a.status = ST_UNUSED;
                else if (act == ACT_DUP)
                    map_count[s] = (cur < COUNT_MAX) ? cur + 1'b1 : COUNT_MAX;
                else if (act == ACT_COUNT) a.count = cur;
                else if (cur < COUNT_MAX) begin
                    if (cur < amt) a.status = ST_UNDERFLOW;
                    else begin
                        cur = cur - amt;
                        map_count[s] = cur;
                        if (cur == '0) begin
                            if (s < low_mark) low_mark = s;
                            if (s > high_mark) high_mark = s;
                            free_cnt++;
                        end
                    end
                end
            end
        end
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            foreach (map_count[k]) map_count[k] = '0;
            map_count[0] = COUNT_BAD;
            low_mark  = 1;
            high_mark = SLOTS - 1;
            clu_pos   = 0;
            clu_left  = 0;
            free_cnt  = SLOTS - 1;
            clu_size  = CSZ_W'(CLUSTER_LIMIT);
            due_answers.delete();
            o_errors  = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) clu_size = i_cfg_data;
            // result first: an item accepted now answers no earlier than next cycle
            if (i_done) begin
                if (due_answers.size() == 0) begin
                    o_errors++;
                    $display("%0t: result with nothing expected (slot %0d count %0d st %0d)",
                             $time, i_result_slot, i_ref_count, i_status);
                end else begin
                    want = due_answers.pop_front();
                    if (want.slot !== i_result_slot) begin
                        o_errors++;
                        $display("%0t: result_slot expected %0d actual %0d",
                                 $time, want.slot, i_result_slot);
                    end
                    if (want.count !== i_ref_count) begin
                        o_errors++;
                        $display("%0t: ref_count expected %0d actual %0d",
                                 $time, want.count, i_ref_count);
                    end
                    if (want.status !== i_status) begin
                        o_errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, i_status);
                    end
                end
            end
            if (i_start && !i_busy)
                due_answers.push_back(apply_command(i_action, i_slot, i_amount));
        end
        o_pending = due_answers.size();
    end
endmodule

// ===== tb/swap_slot_allocator_refcount_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swap_slot_allocator_refcount_test
// Drives directed and random commands into the slot allocator across several
// cluster sizes; a side checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module swap_slot_allocator_refcount_test;
    import ssa_pkg::*;

    // actions the block must answer with all zeros
    localparam logic [2:0] ACT_NONE_A = 3'd5;
    localparam logic [2:0] ACT_NONE_B = 3'd6;
    localparam logic [2:0] ACT_NONE_C = 3'd7;
    localparam int WATCH_LIMIT = 40000;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               start = 0;
    logic               busy;
    logic [2:0]         action = ACT_COUNT;
    logic [SLOT_W-1:0]  slot = '0;
    logic [AMT_W-1:0]   amount = '0;
    logic               done;
    logic [SLOT_W-1:0]  res_slot;
    logic [CNT_W-1:0]   res_count;
    logic [2:0]         res_status;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic [CSZ_W-1:0]   cfg_data = '0;
    int                 errors, pending;

    // steering state: recently handed-out slots, per-action tallies
    t_slot  recent_slots[$];
    int     n_items, n_alloc, n_nospace, n_cfg, idle_cycles;
    int     cur_alloc_pct;
    bit     wide_slots;

    always #5 clk = ~clk;

    swap_slot_allocator_refcount uut (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_action(action), .i_slot(slot), .i_amount(amount),
        .o_done(done), .o_result_slot(res_slot), .o_ref_count(res_count),
        .o_status(res_status), .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_data(cfg_data)
    );

    ssa_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy),
        .i_action(action), .i_slot(slot), .i_amount(amount),
        .i_done(done), .i_result_slot(res_slot), .i_ref_count(res_count),
        .i_status(res_status), .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_data(cfg_data), .o_errors(errors), .o_pending(pending)
    );

    // harvest allocated slots so later commands hit live entries
    always @(posedge clk) begin
        if (rst_n && done) begin
            if (res_slot != '0) begin
                recent_slots.push_back(res_slot);
                if (recent_slots.size() > 64) void'(recent_slots.pop_front());
                n_alloc++;
            end
            if (res_status == ST_NOSPACE) n_nospace++;
        end
    end

    // watchdog: cycles with no handshake of any kind
    always @(posedge clk) begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("swap_slot_allocator_refcount_test: done, errors");
            $finish;
        end
    end

    // one command; called and returns at a falling edge, start left high
    task automatic issue(logic [2:0] act, t_slot s, logic [AMT_W-1:0] amt,
                         int gap);
        if (gap > 0) begin
            start = 0;
            repeat (gap) @(negedge clk);
        end
        action = act;
        slot   = s;
        amount = amt;
        start  = 1;
        forever begin
            @(posedge clk);
            if (!busy) break;
        end
        @(negedge clk);
        n_items++;
    endtask

    // register write only once the block has drained
    task automatic write_cluster(logic [CSZ_W-1:0] val);
        start = 0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_valid = 1;
        cfg_data  = val;
        forever begin
            @(posedge clk);
            if (cfg_ready) break;
        end
        @(negedge clk);
        cfg_valid = 0;
        n_cfg++;
    endtask

    function automatic t_slot pick_slot();
        int r;
        r = $urandom_range(0, 99);
        if (!wide_slots && r < 70 && recent_slots.size() > 0)
            return recent_slots[$urandom_range(0, recent_slots.size() - 1)];
        if (r < 85) return t_slot'($urandom_range(0, 3));
        return t_slot'($urandom);
    endfunction

    function automatic logic [AMT_W-1:0] pick_amount(logic [2:0] act);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return AMT_W'($urandom);
        if (r < 8)  return AMT_W'($urandom_range(32765, 32767));
        if (r < 12) return '0;
        if (act == ACT_FREE && r < 20) return AMT_W'($urandom_range(4, 40));
        return AMT_W'($urandom_range(1, 4));
    endfunction

    task automatic random_item(int idx);
        int r;
        int gap;
        logic [2:0] act;
        r = $urandom_range(0, 99);
        if (r < cur_alloc_pct) act = ACT_ALLOC;
        else begin
            r = $urandom_range(0, 99);
            if      (r < 20) act = ACT_DUP;
            else if (r < 60) act = ACT_FREE;
            else if (r < 85) act = ACT_COUNT;
            else if (r < 93) act = ACT_BAD;
            else             act = 3'($urandom);
        end
        // every third stretch of 40 items runs back to back
        gap = ((idx / 40) % 3 == 0) ? 0 : $urandom_range(0, 17);
        issue(act, pick_slot(), pick_amount(act), gap);
    endtask

    initial begin
        int cfg_vals[6];
        int counts[6];
        int pcts[6];
        bit wides[6];
        cfg_vals = '{256, 1, 511, 0, 3, 0};
        counts   = '{200, 200, 150, 500, 200, 100};
        pcts     = '{50, 45, 55, 95, 25, 50};
        wides    = '{0, 0, 0, 0, 1, 1};
        cfg_vals[5] = $urandom_range(1, 256);

        repeat (2) @(negedge clk);
        rst_n = 1;

        // directed: limits, saturation, permanent and bad slots, odd actions
        issue(ACT_COUNT, '0, '0, 0);
        issue(ACT_ALLOC, '0, 15'h7FFF, 0);
        issue(ACT_ALLOC, '0, 15'h7FFE, 1);
        issue(ACT_DUP, 10'd1, '0, 0);
        issue(ACT_DUP, 10'd1, '0, 0);
        issue(ACT_FREE, 10'd1, 15'd5, 2);
        issue(ACT_COUNT, 10'd1, '0, 0);
        issue(ACT_ALLOC, '0, '0, 0);
        issue(ACT_COUNT, 10'd2, '0, 0);
        issue(ACT_ALLOC, '0, 15'd3, 3);
        issue(ACT_FREE, 10'd3, 15'd7, 0);
        issue(ACT_FREE, 10'd3, 15'd3, 0);
        issue(ACT_BAD, 10'd1023, '0, 0);
        issue(ACT_DUP, 10'd1023, '0, 0);
        issue(ACT_COUNT, 10'd1023, '0, 0);
        issue(ACT_FREE, '0, 15'd1, 0);
        issue(ACT_BAD, '0, '0, 0);
        issue(ACT_DUP, '0, '0, 0);
        issue(ACT_FREE, 10'd500, 15'h7FFF, 0);
        issue(ACT_NONE_A, 10'h3FF, 15'h7FFF, 0);
        issue(ACT_NONE_B, 10'd7, 15'd1, 0);
        issue(ACT_NONE_C, '0, '0, 0);
        issue(ACT_ALLOC, '0, 15'd1, 0);

        // random phases, each under its own cluster size; phase 3 allocates most often,
        // the later ones free across the whole map to widen the marks again
        for (int p = 0; p < 6; p++) begin
            write_cluster(CSZ_W'(cfg_vals[p]));
            cur_alloc_pct = pcts[p];
            wide_slots    = wides[p];
            for (int i = 0; i < counts[p]; i++) random_item(i);
        end

        start = 0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);

        $display("Covered %0d commands over %0d cluster sizes: %0d slots handed out, %0d no-space answers.",
                 n_items, n_cfg, n_alloc, n_nospace);
        if (errors == 0 && pending == 0)
            $display("swap_slot_allocator_refcount_test: done, clean");
        else
            $display("swap_slot_allocator_refcount_test: done, errors");
        $finish;
    end
endmodule

// ===== files.f =====
sv/ssa_pkg.sv
sv/ssa_ram.sv
sv/swap_slot_allocator_refcount.sv
tb/ssa_checker.sv
tb/swap_slot_allocator_refcount_test.sv
